// ----- rtl/core/cursor_line_edit_buffer_top_assert.svh -----
// Assertion macros shared by the line-edit buffer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef CURSOR_LINE_EDIT_BUFFER_TOP_ASSERT_SVH
`define CURSOR_LINE_EDIT_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define CLEB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CLEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Invariant that holds at every edge outside reset.
`define CLEB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

// ----- rtl/core/cleb_pkg.sv -----
// Types and constants for the cursor line-edit buffer.
// No dependencies; used by cleb_ctrl and the top level.
package cleb_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 11;
   localparam int CHAR_W   = 8;
   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 10;

   typedef enum logic [MODE_W-1:0] {
      MODE_LEFT   = 3'd0,
      MODE_RIGHT  = 3'd1,
      MODE_BACK   = 3'd2,
      MODE_INSERT = 3'd3,
      MODE_READ   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_NOOP  = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_NONE   = 2'd0,
      SEL_BEFORE = 2'd1,
      SEL_AFTER  = 2'd2
   } sel_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CHAR_W-1:0]  char_in;
      logic [INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic [LEN_W-1:0]  text_length;
      logic [LEN_W-1:0]  cursor_pos;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CHAR_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_cmd_type;

endpackage

// ----- rtl/core/cleb_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module cleb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cleb_ctrl.sv -----
// Sequencer of the line-edit buffer: decodes a request, keeps the two stack
// counts, drives both stack RAMs and builds the response. Uses cleb_pkg and
// cursor_line_edit_buffer_top_assert.svh.
`include "cursor_line_edit_buffer_top_assert.svh"

module cleb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  cleb_pkg::req_type             req_data,
   output logic                          busy,
   output cleb_pkg::ram_cmd_type         bs_cmd,
   output cleb_pkg::ram_cmd_type         as_cmd,
   input  logic [cleb_pkg::CHAR_W-1:0]   bs_rdata,
   input  logic [cleb_pkg::CHAR_W-1:0]   as_rdata,
   output logic                          rsp_valid,
   output cleb_pkg::rsp_type             rsp_data
);

   localparam logic [cleb_pkg::LEN_W-1:0] CapLen = cleb_pkg::LEN_W'(cleb_pkg::CAPACITY);

   cleb_pkg::ctrl_state_type state_ff, state_in;
   logic [cleb_pkg::LEN_W-1:0]  bcnt_ff, bcnt_in;
   logic [cleb_pkg::LEN_W-1:0]  acnt_ff, acnt_in;
   cleb_pkg::sel_type           wsel_ff, wsel_in;
   cleb_pkg::sel_type           rsel_ff, rsel_in;
   logic                        wchar_ff, wchar_in;
   logic [cleb_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [cleb_pkg::ADDR_W-1:0] waddr_ff, waddr_in;
   cleb_pkg::status_type        status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cleb_pkg::rsp_type           rsp_ff, rsp_in;

   logic [cleb_pkg::LEN_W-1:0]  len_w;
   logic [cleb_pkg::LEN_W-1:0]  idx_w;
   logic [cleb_pkg::CHAR_W-1:0] wdata_w;
   logic [cleb_pkg::CHAR_W-1:0] rd_char_w;

   assign len_w = bcnt_ff + acnt_ff;
   assign idx_w = cleb_pkg::LEN_W'(req_data.read_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cleb_pkg::CS_IDLE;
         bcnt_ff      <= '0;
         acnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bcnt_ff      <= bcnt_in;
         acnt_ff      <= acnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wsel_ff   <= wsel_in;
      rsel_ff   <= rsel_in;
      wchar_ff  <= wchar_in;
      char_ff   <= char_in;
      waddr_ff  <= waddr_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // Write data for a move comes straight from the other stack's read port.
   always_comb begin
      if (wchar_ff) begin
         wdata_w = char_ff;
      end else if (wsel_ff == cleb_pkg::SEL_BEFORE) begin
         wdata_w = as_rdata;
      end else begin
         wdata_w = bs_rdata;
      end
   end

   always_comb begin
      case (rsel_ff)
         cleb_pkg::SEL_BEFORE: rd_char_w = bs_rdata;
         cleb_pkg::SEL_AFTER:  rd_char_w = as_rdata;
         default:              rd_char_w = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      bcnt_in      = bcnt_ff;
      acnt_in      = acnt_ff;
      wsel_in      = wsel_ff;
      rsel_in      = rsel_ff;
      wchar_in     = wchar_ff;
      char_in      = char_ff;
      waddr_in     = waddr_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      bs_cmd       = '0;
      as_cmd       = '0;

      unique case (state_ff)
         cleb_pkg::CS_IDLE: begin
            if (start) begin
               state_in  = cleb_pkg::CS_EXEC;
               wsel_in   = cleb_pkg::SEL_NONE;
               rsel_in   = cleb_pkg::SEL_NONE;
               wchar_in  = 1'b0;
               char_in   = req_data.char_in;
               waddr_in  = '0;
               status_in = cleb_pkg::STAT_DONE;
               unique case (req_data.mode)
                  cleb_pkg::MODE_LEFT: begin
                     if (bcnt_ff == '0 || acnt_ff >= CapLen) begin
                        status_in = cleb_pkg::STAT_NOOP;
                     end else begin
                        bs_cmd.raddr = cleb_pkg::ADDR_W'(bcnt_ff - 1'b1);
                        wsel_in      = cleb_pkg::SEL_AFTER;
                        waddr_in     = cleb_pkg::ADDR_W'(acnt_ff);
                        bcnt_in      = bcnt_ff - 1'b1;
                        acnt_in      = acnt_ff + 1'b1;
                     end
                  end
                  cleb_pkg::MODE_RIGHT: begin
                     if (acnt_ff == '0 || bcnt_ff >= CapLen) begin
                        status_in = cleb_pkg::STAT_NOOP;
                     end else begin
                        as_cmd.raddr = cleb_pkg::ADDR_W'(acnt_ff - 1'b1);
                        wsel_in      = cleb_pkg::SEL_BEFORE;
                        waddr_in     = cleb_pkg::ADDR_W'(bcnt_ff);
                        acnt_in      = acnt_ff - 1'b1;
                        bcnt_in      = bcnt_ff + 1'b1;
                     end
                  end
                  cleb_pkg::MODE_BACK: begin
                     if (bcnt_ff == '0) begin
                        status_in = cleb_pkg::STAT_NOOP;
                     end else begin
                        bcnt_in = bcnt_ff - 1'b1;
                     end
                  end
                  cleb_pkg::MODE_INSERT: begin
                     if (len_w >= CapLen) begin
                        status_in = cleb_pkg::STAT_FULL;
                     end else begin
                        wsel_in  = cleb_pkg::SEL_BEFORE;
                        wchar_in = 1'b1;
                        waddr_in = cleb_pkg::ADDR_W'(bcnt_ff);
                        bcnt_in  = bcnt_ff + 1'b1;
                     end
                  end
                  cleb_pkg::MODE_READ: begin
                     if (idx_w < bcnt_ff) begin
                        bs_cmd.raddr = cleb_pkg::ADDR_W'(idx_w);
                        rsel_in      = cleb_pkg::SEL_BEFORE;
                     end else if (idx_w < len_w) begin
                        // after stack is stored top-last: position maps downward
                        as_cmd.raddr = cleb_pkg::ADDR_W'(len_w - idx_w - 1'b1);
                        rsel_in      = cleb_pkg::SEL_AFTER;
                     end else begin
                        status_in = cleb_pkg::STAT_RANGE;
                     end
                  end
                  default: begin
                     status_in = cleb_pkg::STAT_NOOP;
                  end
               endcase
            end
         end
         cleb_pkg::CS_EXEC: begin
            state_in     = cleb_pkg::CS_IDLE;
            bs_cmd.we    = (wsel_ff == cleb_pkg::SEL_BEFORE);
            bs_cmd.waddr = waddr_ff;
            bs_cmd.wdata = wdata_w;
            as_cmd.we    = (wsel_ff == cleb_pkg::SEL_AFTER);
            as_cmd.waddr = waddr_ff;
            as_cmd.wdata = wdata_w;
            rsp_valid_in = 1'b1;
            rsp_in.char_out    = rd_char_w;
            rsp_in.text_length = len_w;
            rsp_in.cursor_pos  = bcnt_ff;
            rsp_in.status      = status_ff;
         end
         default: begin
            state_in = cleb_pkg::CS_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff == cleb_pkg::CS_EXEC);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CLEB_ASSERT_NEXT(a_accept_to_exec, clock, reset, start && !busy, state_ff == cleb_pkg::CS_EXEC, "accepted beat did not enter execute")
   `CLEB_ASSERT_NEXT(a_exec_to_rsp, clock, reset, state_ff == cleb_pkg::CS_EXEC, rsp_valid_ff, "execute cycle gave no response beat")
   `CLEB_ASSERT_IMPLY(a_one_write, clock, reset, bs_cmd.we || as_cmd.we, !(bs_cmd.we && as_cmd.we) && busy, "stack write outside execute or to both stacks")
   `CLEB_ASSERT_ALWAYS(a_len_cap, clock, reset, ({1'b0, bcnt_ff} + {1'b0, acnt_ff}) <= {1'b0, CapLen}, "text length above capacity")

endmodule

// ----- rtl/core/cursor_line_edit_buffer_top.sv -----
// An accepted request moves the controller into its execute state, from which the
// response strobe is registered; no new request is taken while busy is high. Busy is
// high in the cycle after an accept, while RAM reads return and the write-back happens.
// Reset (synchronous) empties the buffer; stack RAM contents are not cleared.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// Top level of the gap-buffer line editor; uses cleb_pkg, cleb_ram and cleb_ctrl.
module cursor_line_edit_buffer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cleb_pkg::req_type req_data,
   output logic              rsp_valid,
   output cleb_pkg::rsp_type rsp_data
);

   cleb_pkg::ram_cmd_type       bs_cmd;
   cleb_pkg::ram_cmd_type       as_cmd;
   logic [cleb_pkg::CHAR_W-1:0] bs_rdata;
   logic [cleb_pkg::CHAR_W-1:0] as_rdata;

   cleb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .bs_cmd    (bs_cmd),
      .as_cmd    (as_cmd),
      .bs_rdata  (bs_rdata),
      .as_rdata  (as_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   cleb_ram #(
      .DEPTH (cleb_pkg::CAPACITY),
      .WIDTH (cleb_pkg::CHAR_W)
   ) u_before_ram (
      .clock   (clock),
      .wr_en   (bs_cmd.we),
      .wr_addr (bs_cmd.waddr),
      .wr_data (bs_cmd.wdata),
      .rd_addr (bs_cmd.raddr),
      .rd_data (bs_rdata)
   );

   cleb_ram #(
      .DEPTH (cleb_pkg::CAPACITY),
      .WIDTH (cleb_pkg::CHAR_W)
   ) u_after_ram (
      .clock   (clock),
      .wr_en   (as_cmd.we),
      .wr_addr (as_cmd.waddr),
      .wr_data (as_cmd.wdata),
      .rd_addr (as_cmd.raddr),
      .rd_data (as_rdata)
   );

endmodule
